### hdl/imm_pkg.sv
`timescale 1ns / 1ps

package imm_pkg;

   localparam int DIM    = 16;
   localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int ROW_W  = 4;
   localparam int COL_W  = 4;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int SUM_W  = 38;

   typedef enum logic [1:0] {
      REQ_WRITE_A = 2'd0,
      REQ_WRITE_B = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   typedef logic [IDX_W-1:0]        idx_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef val_type [DIM-1:0]       vrow_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      idx_type          k;
      logic [ROW_W-1:0] row;
   } stage_type;

   typedef struct packed {
      logic acc_en;
      logic first;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

### hdl/integer_matrix_multiply.sv
`timescale 1ns / 1ps

// Signed 16x16 matrix multiplier built from a row of 16 multiply-accumulate cells.
// Input: a transaction is taken when start is high and busy is low. req_type
// selects a write of one element of A or B (req_row, req_col, req_value) or a
// compute of output row req_row. Writes take effect at once and give no result.
// A compute reads the left matrix row and one right matrix row per cycle from
// the two row-wide stores; cell j accumulates output column j.
// busy is high from a compute being taken until its last right row is addressed,
// so row fetches never overlap; writes are taken every cycle while busy is low.
// Output: once the last rows are read from the stores, each sum passes the store
// read register and the product register into its cell's hold register; the 16
// sums are shifted along the cell chain, one per cycle on consecutive cycles,
// each marked by rsp_strobe for one cycle, column 0 first, rsp_last on column 15.
// The receiver cannot stall; draining overlaps the next compute.
// csr_we writes csr_wdata into the product order bit (0: A*B, 1: B*A); write
// it only while no compute is in flight.
// Reset clears the control state and the order bit; the stores are not
// cleared and must be written before they are read.

module integer_matrix_multiply
   import imm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_type,
   input  logic [ROW_W-1:0] req_row,
   input  logic [COL_W-1:0] req_col,
   input  val_type          req_value,
   output logic             rsp_strobe,
   output logic [ROW_W-1:0] rsp_out_row,
   output logic [COL_W-1:0] rsp_out_col,
   output sum_type          rsp_sum,
   output logic             rsp_last,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   logic order_ff, order_in;
   logic busy_ff, busy_in;
   logic issue_ff, issue_in;
   idx_type k_ff, k_in;
   logic [ROW_W-1:0] row_ff, row_in;
   stage_type s0, s1_ff, s2_ff;
   logic drain_ff, drain_in;
   idx_type j_ff, j_in;
   logic [ROW_W-1:0] drain_row_ff, drain_row_in;

   logic accept, row_ok, col_ok, start_compute, wr_a, wr_b, load;
   idx_type addr_a, addr_b;
   vrow_type rd_a, rd_b, left_row, right_row;
   val_type left_elem;
   cell_ctl_type cell_ctl;
   sum_type hold_chain [DIM+1];

   always_comb begin
      accept        = start && !busy_ff;
      row_ok        = int'(req_row) < DIM;
      col_ok        = int'(req_col) < DIM;
      start_compute = accept && (req_type == REQ_COMPUTE) && row_ok;
      wr_a          = accept && (req_type == REQ_WRITE_A) && row_ok && col_ok;
      wr_b          = accept && (req_type == REQ_WRITE_B) && row_ok && col_ok;
      load          = s2_ff.valid && s2_ff.last;

      order_in = csr_we ? csr_wdata : order_ff;

      busy_in  = busy_ff;
      issue_in = issue_ff;
      k_in     = k_ff;
      row_in   = row_ff;
      if (start_compute) begin
         busy_in  = (DIM > 1);
         issue_in = 1'b1;
         k_in     = '0;
         row_in   = req_row;
      end else if (issue_ff) begin
         k_in = k_ff + idx_type'(1);
         if (k_ff == idx_type'(DIM - 2)) begin
            busy_in = 1'b0;
         end
         if (k_ff == idx_type'(DIM - 1)) begin
            issue_in = 1'b0;
         end
      end

      s0.valid = issue_ff;
      s0.last  = (k_ff == idx_type'(DIM - 1));
      s0.k     = k_ff;
      s0.row   = row_ff;

      addr_a = order_ff ? k_ff : idx_type'(row_ff);
      addr_b = order_ff ? idx_type'(row_ff) : k_ff;

      left_row  = order_ff ? rd_b : rd_a;
      right_row = order_ff ? rd_a : rd_b;
      left_elem = left_row[s1_ff.k];

      cell_ctl.acc_en = s2_ff.valid;
      cell_ctl.first  = (s2_ff.k == '0);
      cell_ctl.load   = load;
      cell_ctl.shift  = drain_ff;

      drain_in     = drain_ff;
      j_in         = j_ff;
      drain_row_in = drain_row_ff;
      priority if (load) begin
         drain_in     = 1'b1;
         j_in         = '0;
         drain_row_in = s2_ff.row;
      end else if (drain_ff) begin
         j_in = j_ff + idx_type'(1);
         if (j_ff == idx_type'(DIM - 1)) begin
            drain_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         busy_ff  <= 1'b0;
         issue_ff <= 1'b0;
         k_ff     <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         drain_ff <= 1'b0;
         j_ff     <= '0;
      end else begin
         order_ff <= order_in;
         busy_ff  <= busy_in;
         issue_ff <= issue_in;
         k_ff     <= k_in;
         s1_ff    <= s0;
         s2_ff    <= s1_ff;
         drain_ff <= drain_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      drain_row_ff <= drain_row_in;
   end

   imm_store u_store_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_row  (idx_type'(req_row)),
      .wr_col  (idx_type'(req_col)),
      .wr_data (req_value),
      .rd_row  (addr_a),
      .rd_data (rd_a)
   );

   imm_store u_store_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_row  (idx_type'(req_row)),
      .wr_col  (idx_type'(req_col)),
      .wr_data (req_value),
      .rd_row  (addr_b),
      .rd_data (rd_b)
   );

   assign hold_chain[DIM] = '0;

   for (genvar j = 0; j < DIM; j++) begin : g_cell
      imm_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .left_elem  (left_elem),
         .right_elem (right_row[j]),
         .hold_next  (hold_chain[j+1]),
         .hold_out   (hold_chain[j])
      );
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = drain_ff;
   assign rsp_out_row = drain_row_ff;
   assign rsp_out_col = COL_W'(j_ff);
   assign rsp_sum     = hold_chain[0];
   assign rsp_last    = (j_ff == idx_type'(DIM - 1));

   a_busy_issue: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> issue_ff)
      else $error("busy without fetch in progress");

   a_load_no_overlap: assert property (@(posedge clock) disable iff (reset)
      load |-> (!drain_ff || j_ff == idx_type'(DIM - 1)))
      else $error("row load while previous row still draining");

   a_write_vs_fetch: assert property (@(posedge clock) disable iff (reset)
      (wr_a || wr_b) |-> (!issue_ff || k_ff == idx_type'(DIM - 1)))
      else $error("store write during row fetch");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> (!rsp_strobe || rsp_out_col == '0))
      else $error("result after last element of a row");

endmodule

### hdl/imm_store.sv
`timescale 1ns / 1ps

module imm_store
   import imm_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  idx_type  wr_row,
   input  idx_type  wr_col,
   input  val_type  wr_data,
   input  idx_type  rd_row,
   output vrow_type rd_data
);

   vrow_type mem_ff [DIM];
   vrow_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row][wr_col] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_row];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/imm_cell.sv
`timescale 1ns / 1ps

module imm_cell
   import imm_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  val_type      left_elem,
   input  val_type      right_elem,
   input  sum_type      hold_next,
   output sum_type      hold_out
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   sum_type acc_ff, acc_in, hold_ff, hold_in, prod_ext, total;

   always_comb begin
      prod_in  = left_elem * right_elem;
      prod_ext = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      total    = ctl.first ? prod_ext : acc_ff + prod_ext;
      acc_in   = ctl.acc_en ? total : acc_ff;
      priority if (ctl.load) begin
         hold_in = total;
      end else if (ctl.shift) begin
         hold_in = hold_next;
      end else begin
         hold_in = hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      hold_ff <= hold_in;
   end

   assign hold_out = hold_ff;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import imm_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         N_STEPS      = 20;
   localparam int         N_PHASES     = 4;
   localparam int         PHASE_ITEMS  = 28;
   localparam sum_type    FULL_NEG_SUM = 38'sd17179869184;

   typedef struct {
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      sum_type          sum;
      logic             last;
   } element_type;

   typedef struct packed {
      logic             is_cfg;
      logic [1:0]       code;
      logic [ROW_W-1:0] r;
      logic [COL_W-1:0] c;
      val_type          v;
      logic             typed;
      sum_type          typed_sum;
   } step_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic [1:0]       req_type;
   logic [ROW_W-1:0] req_row;
   logic [COL_W-1:0] req_col;
   val_type          req_value;
   logic             rsp_strobe;
   logic [ROW_W-1:0] rsp_out_row;
   logic [COL_W-1:0] rsp_out_col;
   sum_type          rsp_sum;
   logic             rsp_last;
   logic             csr_we;
   logic             csr_wdata;

   val_type     store_a [DIM][DIM];
   val_type     store_b [DIM][DIM];
   logic        predicted_order;
   element_type pending_elements [$];
   int          error_count;
   bit          no_gaps;

   step_type directed_steps [N_STEPS] = '{
      '{1'b1, REQ_WRITE_A, 4'd0,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b1, FULL_NEG_SUM},
      '{1'b0, REQ_COMPUTE, 4'd15, 4'd15, -16'sd1,    1'b1, FULL_NEG_SUM},
      '{1'b0, REQ_WRITE_A, 4'd15, 4'd15, 16'sd32767, 1'b0, 38'sd0},
      '{1'b0, REQ_WRITE_B, 4'd15, 4'd0,  16'sd32767, 1'b0, 38'sd0},
      '{1'b0, REQ_WRITE_B, 4'd0,  4'd15, 16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_UNUSED,  4'd15, 4'd14, 16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd15, 4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_UNUSED,  4'd0,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_WRITE_A, 4'd7,  4'd3,  -16'sd1,    1'b0, 38'sd0},
      '{1'b0, REQ_WRITE_B, 4'd3,  4'd9,  16'sd1,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd7,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b1, REQ_WRITE_A, 4'd0,  4'd0,  16'sd1,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd15, 4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd3,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_WRITE_A, 4'd0,  4'd0,  16'sd32767, 1'b0, 38'sd0},
      '{1'b0, REQ_COMPUTE, 4'd0,  4'd0,  16'sd0,     1'b0, 38'sd0},
      '{1'b0, REQ_UNUSED,  4'd15, 4'd15, -16'sd1,    1'b0, 38'sd0}
   };

   integer_matrix_multiply u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_sum     (rsp_sum),
      .rsp_last    (rsp_last),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic val_type pick_value();
      unique case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         default: return val_type'($urandom);
      endcase
   endfunction

   // Update the element stores and queue the row of sums a compute yields.
   task automatic predict_row_product(input logic [1:0] code, input logic [ROW_W-1:0] r,
                                      input logic [COL_W-1:0] c, input val_type v,
                                      input logic typed, input sum_type typed_sum);
      element_type elem;
      longint      acc;
      unique case (code)
         REQ_WRITE_A: store_a[r][c] = v;
         REQ_WRITE_B: store_b[r][c] = v;
         REQ_COMPUTE: begin
            for (int j = 0; j < DIM; j++) begin
               acc = 0;
               for (int k = 0; k < DIM; k++) begin
                  if (predicted_order)
                     acc += longint'(store_b[r][k]) * longint'(store_a[k][j]);
                  else
                     acc += longint'(store_a[r][k]) * longint'(store_b[k][j]);
               end
               elem.out_row = r;
               elem.out_col = COL_W'(j);
               elem.sum     = typed ? typed_sum : acc[SUM_W-1:0];
               elem.last    = (j == DIM - 1);
               pending_elements.push_back(elem);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_request(input logic [1:0] code, input logic [ROW_W-1:0] r,
                               input logic [COL_W-1:0] c, input val_type v,
                               input logic typed, input sum_type typed_sum);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= code;
      req_row   <= r;
      req_col   <= c;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_row_product(code, r, c, v, typed, typed_sum);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_product_order(input logic order);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= order;
      @(posedge clock);
      csr_we    <= 1'b0;
      predicted_order = order;
   endtask

   always @(posedge clock) begin : check_results
      element_type want;
      if (!reset && rsp_strobe) begin
         if (pending_elements.size() == 0) begin
            $error("unexpected transaction: row %0d col %0d sum %0d last %0b",
                   rsp_out_row, rsp_out_col, rsp_sum, rsp_last);
            error_count++;
         end else begin
            want = pending_elements.pop_front();
            if (rsp_out_row !== want.out_row) begin
               $error("out_row: expected %0d, actual %0d", want.out_row, rsp_out_row);
               error_count++;
            end
            if (rsp_out_col !== want.out_col) begin
               $error("out_col: expected %0d, actual %0d", want.out_col, rsp_out_col);
               error_count++;
            end
            if (rsp_sum !== want.sum) begin
               $error("sum: expected %0d, actual %0d", want.sum, rsp_sum);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [1:0] code;
      int         roll;
      error_count     = 0;
      predicted_order = 1'b0;
      no_gaps         = 1'b0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_type  <= REQ_WRITE_A;
      req_row   <= '0;
      req_col   <= '0;
      req_value <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Load both stores with the most negative element so no entry is read unwritten.
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            send_request(REQ_WRITE_A, ROW_W'(r), COL_W'(c), 16'sh8000, 1'b0, '0);
            send_request(REQ_WRITE_B, ROW_W'(r), COL_W'(c), 16'sh8000, 1'b0, '0);
         end
      end

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg)
            write_product_order(directed_steps[i].v[0]);
         else
            send_request(directed_steps[i].code, directed_steps[i].r, directed_steps[i].c,
                         directed_steps[i].v, directed_steps[i].typed,
                         directed_steps[i].typed_sum);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         write_product_order(phase[0] ^ 1'b1);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 34)
               code = REQ_WRITE_A;
            else if (roll < 68)
               code = REQ_WRITE_B;
            else if (roll < 92)
               code = REQ_COMPUTE;
            else
               code = REQ_UNUSED;
            send_request(code, ROW_W'($urandom), COL_W'($urandom), pick_value(), 1'b0, '0);
         end
      end

      wait_drained();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
